// ===== rtl/ptp_pkg.sv =====
// shared constants, types and codes for the projective point transform
package ptp_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;               // coordinate and matrix entry width
  localparam int PW        = 2 * CW;           // product width
  localparam int SW        = PW + 3;           // row sum width, signed
  localparam int NW        = SW + FRAC_BITS;   // scaled numerator magnitude width
  localparam int QW        = 32;               // quotient bits produced by the divider
  localparam int DIV_STEPS = QW;

  // configuration registers
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 4;
  localparam int REG_W    = 64;
  localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;
  localparam logic [REG_W-1:0] ONE_FIX = REG_W'(1) << FRAC_BITS;

  // operation codes
  localparam logic OP_AFFINE     = 1'b0;
  localparam logic OP_PROJECTIVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // saturation limits
  localparam logic [CW-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] NEG_MAX = 32'h8000_0000;

  // per lane side information that rides along the divider
  typedef struct packed {
    logic [CW-1:0] aff_val;
    logic          aff_sat;
    logic          neg;      // quotient sign
    logic          ovf;      // quotient needs more than QW bits
    logic          snz;      // numerator nonzero
    logic          sneg;     // numerator negative
  } lane_info_t;

  typedef struct packed {
    logic             op;
    logic             wzero;
    lane_info_t [2:0] lane;
  } ctl_t;

endpackage

// ===== rtl/point_transform_projective_top.sv =====
// top level: 4x4 homogeneous point transform with optional divide by w
//
// One point is taken in every clock cycle and busy never rises. Each result
// appears with done high for one cycle, after the row multiplies and sums, a
// register for sign handling, scaling and the overflow check, the pipelined
// divider (one quotient bit per stage) and one output register. Affine results
// take the same path so order holds. The receiver cannot stall the block.
// Matrix writes go straight to the registers and must be made while no point
// is in flight.
module point_transform_projective_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic signed [31:0]                px,
  input  logic signed [31:0]                py,
  input  logic signed [31:0]                pz,
  input  logic                              wr_en,
  input  logic [ptp_pkg::IDX_W-1:0]         wr_index,
  input  logic [ptp_pkg::REG_W-1:0]         wr_data,
  output logic                              done,
  output logic signed [31:0]                out_x,
  output logic signed [31:0]                out_y,
  output logic signed [31:0]                out_z,
  output logic [1:0]                        status
);

  localparam int N  = ptp_pkg::DIV_STEPS;
  localparam int SW = ptp_pkg::SW;
  localparam int NW = ptp_pkg::NW;
  localparam int F  = ptp_pkg::FRAC_BITS;

  logic [ptp_pkg::REG_W-1:0] mat [ptp_pkg::NUM_REGS];
  logic                      accept;
  logic                      v_a, v_b, v_c;
  logic                      op_a, op_b;
  logic [N:1]                v_div;
  ptp_pkg::ctl_t             ctl [N+1];
  logic signed [SW-1:0]      sum [4];
  logic [SW-1:0]             rem0 [3];
  logic [SW-1:0]             den_c;
  logic [31:0]               numlo [3];
  logic [ptp_pkg::QW-1:0]    quo [3];
  ptp_pkg::ctl_t             ctl_next;
  logic [SW-1:0]             rem0_next [3];
  logic [31:0]               numlo_next [3];
  logic [SW-1:0]             den_next;
  logic [31:0]               res_next [3];
  logic [1:0]                status_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // matrix registers, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptp_pkg::NUM_REGS; i++) begin
        mat[i] <= '0;
      end
      mat[ptp_pkg::REG_ROW0_COLS01[2:0]] <= ptp_pkg::ONE_FIX << 32;
      mat[ptp_pkg::REG_ROW1_COLS01[2:0]] <= ptp_pkg::ONE_FIX;
      mat[ptp_pkg::REG_ROW2_COLS23[2:0]] <= ptp_pkg::ONE_FIX << 32;
      mat[ptp_pkg::REG_ROW3_COLS23[2:0]] <= ptp_pkg::ONE_FIX;
    end else if (wr_en && wr_index < ptp_pkg::IDX_W'(ptp_pkg::NUM_REGS)) begin
      mat[wr_index[2:0]] <= wr_data;
    end
  end

  // four row units
  for (genvar r = 0; r < 4; r++) begin : g_row
    ptp_row u_row (
      .clk (clk),
      .m0  (mat[2*r][63:32]),
      .m1  (mat[2*r][31:0]),
      .m2  (mat[2*r+1][63:32]),
      .m3  (mat[2*r+1][31:0]),
      .px  (px),
      .py  (py),
      .pz  (pz),
      .sum (sum[r])
    );
  end

  // valid and op follow the row units
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      v_a <= accept;
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    op_a <= op;
    op_b <= op_a;
  end

  // prep: magnitudes, affine scaling, divider seed and overflow check
  always_comb begin
    logic               wneg;
    logic [SW-1:0]      smag;
    logic [NW-1:0]      num;
    logic signed [SW-1:0] a;
    wneg     = sum[3][SW-1];
    den_next = wneg ? SW'(-sum[3]) : SW'(sum[3]);
    ctl_next.op    = op_b;
    ctl_next.wzero = (sum[3] == '0);
    for (int k = 0; k < 3; k++) begin
      smag = sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k]);
      num  = {smag, {F{1'b0}}};
      a    = sum[k] >>> F;
      ctl_next.lane[k].sneg    = sum[k][SW-1];
      ctl_next.lane[k].snz     = (sum[k] != '0);
      ctl_next.lane[k].neg     = sum[k][SW-1] ^ wneg;
      ctl_next.lane[k].ovf     = SW'(num[NW-1:32]) >= den_next;
      ctl_next.lane[k].aff_sat = !((&a[SW-1:31]) || !(|a[SW-1:31]));
      if (!ctl_next.lane[k].aff_sat) begin
        ctl_next.lane[k].aff_val = a[31:0];
      end else if (a[SW-1]) begin
        ctl_next.lane[k].aff_val = ptp_pkg::NEG_MAX;
      end else begin
        ctl_next.lane[k].aff_val = ptp_pkg::POS_MAX;
      end
      rem0_next[k]  = SW'(num[NW-1:32]);
      numlo_next[k] = num[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    ctl[0] <= ctl_next;
    den_c  <= den_next;
    for (int k = 0; k < 3; k++) begin
      rem0[k]  <= rem0_next[k];
      numlo[k] <= numlo_next[k];
    end
  end

  // three divider lanes
  for (genvar k = 0; k < 3; k++) begin : g_div
    ptp_div u_div (
      .clk      (clk),
      .rem_in   (rem0[k]),
      .den_in   (den_c),
      .numlo_in (numlo[k]),
      .quo      (quo[k])
    );
  end

  // side information delay matched to the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      v_div <= '0;
    end else begin
      v_div <= {v_div[N-1:1], v_c};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_ctl
    always_ff @(posedge clk) begin
      ctl[i+1] <= ctl[i];
    end
  end

  // result select and status
  always_comb begin
    logic [31:0]  lim;
    logic         psat;
    logic         any_aff;
    logic         any_proj;
    ptp_pkg::lane_info_t li;
    any_aff  = 1'b0;
    any_proj = 1'b0;
    for (int k = 0; k < 3; k++) begin
      li   = ctl[N].lane[k];
      lim  = li.neg ? ptp_pkg::NEG_MAX : ptp_pkg::POS_MAX;
      psat = li.ovf || (quo[k] > lim);
      any_aff  = any_aff | li.aff_sat;
      any_proj = any_proj | psat;
      if (ctl[N].op == ptp_pkg::OP_AFFINE) begin
        res_next[k] = li.aff_val;
      end else if (ctl[N].wzero) begin
        if (!li.snz) begin
          res_next[k] = '0;
        end else begin
          res_next[k] = li.sneg ? ptp_pkg::NEG_MAX : ptp_pkg::POS_MAX;
        end
      end else if (psat) begin
        res_next[k] = lim;
      end else begin
        res_next[k] = li.neg ? (32'd0 - quo[k]) : quo[k];
      end
    end
    if (ctl[N].op == ptp_pkg::OP_AFFINE) begin
      status_next = any_aff ? ptp_pkg::ST_SAT : ptp_pkg::ST_OK;
    end else if (ctl[N].wzero) begin
      status_next = ptp_pkg::ST_WZERO;
    end else begin
      status_next = any_proj ? ptp_pkg::ST_SAT : ptp_pkg::ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_div[N];
    end
  end

  always_ff @(posedge clk) begin
    out_x  <= res_next[0];
    out_y  <= res_next[1];
    out_z  <= res_next[2];
    status <= status_next;
  end

endmodule

// ===== rtl/ptp_row.sv =====
// one matrix row: three products and the translation, then the exact row sum
module ptp_row (
  input  logic                             clk,
  input  logic signed [ptp_pkg::CW-1:0]    m0,
  input  logic signed [ptp_pkg::CW-1:0]    m1,
  input  logic signed [ptp_pkg::CW-1:0]    m2,
  input  logic signed [ptp_pkg::CW-1:0]    m3,
  input  logic signed [ptp_pkg::CW-1:0]    px,
  input  logic signed [ptp_pkg::CW-1:0]    py,
  input  logic signed [ptp_pkg::CW-1:0]    pz,
  output logic signed [ptp_pkg::SW-1:0]    sum
);

  logic signed [ptp_pkg::PW-1:0]                 p0, p1, p2;
  logic signed [ptp_pkg::CW+ptp_pkg::FRAC_BITS-1:0] t3;

  // stage one: multiplies and the scaled translation
  always_ff @(posedge clk) begin
    p0 <= px * m0;
    p1 <= py * m1;
    p2 <= pz * m2;
    t3 <= {m3, {ptp_pkg::FRAC_BITS{1'b0}}};
  end

  // stage two: exact sum
  always_ff @(posedge clk) begin
    sum <= ptp_pkg::SW'(p0) + ptp_pkg::SW'(p1) + ptp_pkg::SW'(p2) + ptp_pkg::SW'(t3);
  end

endmodule

// ===== rtl/ptp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ptp_div (
  input  logic                      clk,
  input  logic [ptp_pkg::SW-1:0]    rem_in,
  input  logic [ptp_pkg::SW-1:0]    den_in,
  input  logic [31:0]               numlo_in,
  output logic [ptp_pkg::QW-1:0]    quo
);

  localparam int N = ptp_pkg::DIV_STEPS;

  logic [ptp_pkg::SW-1:0] rem [1:N-1];
  logic [ptp_pkg::SW-1:0] den [1:N-1];
  logic [31:0]            nl  [1:N-1];
  logic [ptp_pkg::QW-1:0] q   [1:N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [ptp_pkg::SW-1:0] rem_cur;
    logic [ptp_pkg::SW-1:0] den_cur;
    logic [31:0]            nl_cur;
    logic [ptp_pkg::QW-1:0] q_cur;
    logic [ptp_pkg::SW+1:0] diff;
    logic                   ge;

    // first stage takes the seed, later stages take the previous stage
    if (i == 0) begin : g_src
      assign rem_cur = rem_in;
      assign den_cur = den_in;
      assign nl_cur  = numlo_in;
      assign q_cur   = '0;
    end else begin : g_src
      assign rem_cur = rem[i];
      assign den_cur = den[i];
      assign nl_cur  = nl[i];
      assign q_cur   = q[i];
    end

    // trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rem_cur, nl_cur[31]} - {2'b00, den_cur};
    assign ge   = !diff[ptp_pkg::SW+1];

    always_ff @(posedge clk) begin
      q[i+1] <= {q_cur[ptp_pkg::QW-2:0], ge};
    end

    // remainder, divisor and numerator bits for the next stage
    if (i < N-1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem[i+1] <= ge ? diff[ptp_pkg::SW-1:0] : {rem_cur[ptp_pkg::SW-2:0], nl_cur[31]};
        den[i+1] <= den_cur;
        nl[i+1]  <= {nl_cur[30:0], 1'b0};
      end
    end
  end

  assign quo = q[N];

endmodule
